FILE: sv/fas_pkg.sv
// Shared types, opcodes and sizing constants for the frame animation sequencer.
// No dependencies; every other file of the sequencer imports this package.
package fas_pkg;

    // Default sizing handed to the top level parameters.
    localparam int MAX_FRAMES_DEF = 64;
    localparam int TIME_BITS_DEF  = 32;

    // Fixed field widths of the two channels and of the register.
    localparam int OP_W       = 3;
    localparam int TIME_IN_W  = 32;
    localparam int INDEX_W    = 6;
    localparam int REPEAT_W   = 16;
    localparam int FRAME_W    = 6;
    localparam int RATIO_W    = 16;
    localparam int FCOUNT_W   = 7;

    // Ratio saturation value and the number of serial quotient steps.
    localparam logic [RATIO_W-1:0]  RATIO_MAX   = '1;
    localparam logic [REPEAT_W-1:0] REPEAT_MAX  = '1;
    localparam int                  DIV_STEPS   = RATIO_W - 1;
    localparam int                  DIV_CNT_W   = $clog2(DIV_STEPS);

    // Opcodes of an input beat.
    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_START     = 3'd1;
    localparam logic [OP_W-1:0] OP_PAUSE     = 3'd2;
    localparam logic [OP_W-1:0] OP_UNPAUSE   = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_FRAME = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE_DUR = 3'd5;

    // Status that the ratio divider returns to the control logic.
    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] ratio;
    } div_result_t;

endpackage

FILE: sv/fas_dur_table.sv
// Frame duration table: one write port and one registered read port.
// Depends on fas_pkg for the default sizing.
module fas_dur_table
    import fas_pkg::*;
#(
    parameter int DEPTH = MAX_FRAMES_DEF,
    parameter int TW    = TIME_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [TW-1:0]            wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [TW-1:0]            rd_data
);

    logic [TW-1:0] mem [DEPTH];
    logic [TW-1:0] rd_data_reg;

    // Write port; contents are undefined until written.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered every cycle.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fas_ratio_div.sv
// Serial Q1.15 ratio divider: one quotient bit per cycle, saturating at the maximum.
// Depends on fas_pkg for the result struct and the step count.
module fas_ratio_div
    import fas_pkg::*;
#(
    parameter int TW = TIME_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [TW-1:0] dividend,
    input  logic [TW-1:0] divisor,
    output div_result_t   result
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_PRE  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    logic [1:0]           state_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [TW-1:0]        a_reg;
    logic [TW-1:0]        d_reg;
    logic [TW-1:0]        r_reg;
    logic [RATIO_W-1:0]   q_reg;
    logic                 sat_reg;

    logic                 pre_ge;
    logic                 pre_sat;
    logic [TW:0]          dbl;
    logic                 step_ge;
    logic [TW:0]          step_diff;

    // Integer bit: a zero divisor or a ratio of two or more saturates.
    assign pre_ge  = a_reg >= d_reg;
    assign pre_sat = (d_reg == '0) || ({1'b0, a_reg} >= {d_reg, 1'b0});

    // One fraction bit: compare the doubled remainder with the divisor.
    assign dbl       = {r_reg, 1'b0};
    assign step_ge   = dbl >= {1'b0, d_reg};
    assign step_diff = dbl - {1'b0, d_reg};

    // Sequencer of the divider: capture, integer step, then the fraction steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                D_IDLE: begin
                    done_reg <= 1'b0;
                    if (start) begin
                        a_reg     <= dividend;
                        d_reg     <= divisor;
                        state_reg <= D_PRE;
                    end
                end
                D_PRE: begin
                    sat_reg   <= pre_sat;
                    q_reg     <= {{(RATIO_W-1){1'b0}}, pre_ge};
                    r_reg     <= pre_ge ? (a_reg - d_reg) : a_reg;
                    cnt_reg   <= '0;
                    state_reg <= D_RUN;
                end
                D_RUN: begin
                    r_reg <= step_ge ? step_diff[TW-1:0] : dbl[TW-1:0];
                    q_reg <= {q_reg[RATIO_W-2:0], step_ge};
                    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign result.done  = done_reg;
    assign result.ratio = sat_reg ? RATIO_MAX : q_reg;

endmodule

FILE: sv/frame_animation_sequencer_unit.sv
// Top level of the frame animation sequencer: control, state and output register.
// Depends on fas_pkg, fas_dur_table and fas_ratio_div.
//
//   channel | direction | handshake        | payload
//   s_      | in        | s_valid/s_ready  | opcode, elapsed_time, frame_index,
//           |           |                  | repeat_limit_in, duration_value
//   m_      | out       | m_valid/m_ready  | frame, frame_ratio, is_paused, repeats_done
//   cfg_    | in        | cfg_wr_en        | frame_count
//
// A running tick goes from acceptance through the serial divider, which produces one
// quotient bit per cycle, to its result beat; other opcodes skip the divider.
// Reset is synchronous and active low; the duration table is not cleared.
// A result waits in the output register while the next beat is accepted and
// processed; a finished item holds there until the output register is free.
module frame_animation_sequencer_unit
    import fas_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [FCOUNT_W-1:0]  cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_opcode,
    input  logic [TIME_IN_W-1:0] s_elapsed_time,
    input  logic [INDEX_W-1:0]   s_frame_index,
    input  logic [REPEAT_W-1:0]  s_repeat_limit_in,
    input  logic [TIME_IN_W-1:0] s_duration_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAME_W-1:0]   m_frame,
    output logic [RATIO_W-1:0]   m_ratio,
    output logic                 m_paused,
    output logic [REPEAT_W-1:0]  m_repeats_done
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = (AW + 1 > FCOUNT_W) ? AW + 1 : FCOUNT_W;
    localparam int TW = TIME_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg;
    logic [OP_W-1:0]     op_reg;
    logic [TW-1:0]       dt_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [REPEAT_W-1:0] lim_in_reg;
    logic [TW-1:0]       dval_reg;

    logic [FCOUNT_W-1:0] fc_reg;
    logic [AW-1:0]       cur_frame_reg;
    logic [TW-1:0]       acc_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [REPEAT_W-1:0] rep_reg;
    logic [REPEAT_W-1:0] lim_reg;
    logic                paused_reg;

    logic                m_valid_reg;
    logic [FRAME_W-1:0]  m_frame_reg;
    logic [RATIO_W-1:0]  m_ratio_reg;
    logic                m_paused_reg;
    logic [REPEAT_W-1:0] m_rep_reg;

    logic [CW-1:0]       fc_ext;
    logic [CW-1:0]       eff_cnt;
    logic [CW-1:0]       idx_ext;
    logic [CW-1:0]       jump_frame;
    logic [CW-1:0]       cur_ext;
    logic                is_last;
    logic [TW:0]         sum_wide;
    logic [TW-1:0]       sum_sat;
    logic [REPEAT_W-1:0] rep_inc;
    logic                limit_hit;
    logic [TW-1:0]       dur_q;
    logic                acc_over;
    logic                wr_en;
    logic                div_start;
    logic                out_load;
    div_result_t         div_res;

    // Effective frame count: zero acts as one, large values clamp to the table size.
    assign fc_ext  = CW'(fc_reg);
    always_comb begin
        priority if (fc_ext == '0) begin
            eff_cnt = CW'(1);
        end else if (fc_ext > CW'(MAX_FRAMES)) begin
            eff_cnt = CW'(MAX_FRAMES);
        end else begin
            eff_cnt = fc_ext;
        end
    end

    // Frame for start and set frame, clamped to the last frame.
    assign idx_ext    = CW'(idx_reg);
    assign jump_frame = (idx_ext >= eff_cnt) ? (eff_cnt - CW'(1)) : idx_ext;

    // Frame position and saturating accumulator update.
    assign cur_ext  = CW'(cur_frame_reg);
    assign is_last  = (cur_ext + CW'(1)) >= eff_cnt;
    assign sum_wide = {1'b0, acc_reg} + {1'b0, dt_reg};
    assign sum_sat  = sum_wide[TW] ? '1 : sum_wide[TW-1:0];

    // Repeat bookkeeping for a move off the last frame.
    assign rep_inc   = (rep_reg == REPEAT_MAX) ? rep_reg : rep_reg + 1'b1;
    assign limit_hit = (lim_reg != '0) && (rep_inc >= lim_reg);
    assign acc_over  = acc_reg > dur_q;

    assign wr_en     = (state_reg == S_EXEC) && (op_reg == OP_WRITE_DUR) &&
                       (idx_ext < CW'(MAX_FRAMES));
    assign div_start = (state_reg == S_EXEC) && (op_reg == OP_TICK) && !paused_reg;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Duration table, read at the current frame every cycle.
    fas_dur_table #(
        .DEPTH (MAX_FRAMES),
        .TW    (TW)
    ) u_dur_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(idx_reg)),
        .wr_data (dval_reg),
        .rd_addr (cur_frame_reg),
        .rd_data (dur_q)
    );

    // Serial ratio divider on the new accumulator and the current duration.
    fas_ratio_div #(
        .TW (TW)
    ) u_ratio_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_sat),
        .divisor  (dur_q),
        .result   (div_res)
    );

    // Input capture at acceptance.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= s_opcode;
            dt_reg     <= TW'(s_elapsed_time);
            idx_reg    <= s_frame_index;
            lim_in_reg <= s_repeat_limit_in;
            dval_reg   <= TW'(s_duration_value);
        end
    end

    // Frame count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg <= FCOUNT_W'(1);
        end else if (cfg_wr_en) begin
            fc_reg <= cfg_wr_data;
        end
    end

    // Control sequence and animation state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_frame_reg <= '0;
            acc_reg       <= '0;
            ratio_reg     <= '0;
            rep_reg       <= '0;
            lim_reg       <= '0;
            paused_reg    <= 1'b1;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= div_start ? S_WAIT : S_DONE;
                    unique case (op_reg)
                        OP_TICK: begin
                            if (!paused_reg) begin
                                acc_reg <= sum_sat;
                            end
                        end
                        OP_START: begin
                            lim_reg       <= lim_in_reg;
                            rep_reg       <= '0;
                            cur_frame_reg <= AW'(jump_frame);
                            acc_reg       <= '0;
                            ratio_reg     <= '0;
                            paused_reg    <= 1'b0;
                        end
                        OP_PAUSE: begin
                            paused_reg <= 1'b1;
                        end
                        OP_UNPAUSE: begin
                            paused_reg <= 1'b0;
                        end
                        OP_SET_FRAME: begin
                            cur_frame_reg <= AW'(jump_frame);
                            acc_reg       <= '0;
                            ratio_reg     <= '0;
                        end
                        default: begin
                            // Duration writes go to the table; unused codes change nothing.
                        end
                    endcase
                end
                S_WAIT: begin
                    if (div_res.done) begin
                        state_reg <= S_DONE;
                        if (acc_over) begin
                            if (is_last) begin
                                rep_reg <= rep_inc;
                                if (limit_hit) begin
                                    paused_reg <= 1'b1;
                                    ratio_reg  <= div_res.ratio;
                                end else begin
                                    cur_frame_reg <= '0;
                                    acc_reg       <= '0;
                                    ratio_reg     <= '0;
                                end
                            end else begin
                                cur_frame_reg <= cur_frame_reg + 1'b1;
                                acc_reg       <= '0;
                                ratio_reg     <= '0;
                            end
                        end else begin
                            ratio_reg <= div_res.ratio;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output register holding one result beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_frame_reg  <= cur_ext[FRAME_W-1:0];
            m_ratio_reg  <= ratio_reg;
            m_paused_reg <= paused_reg;
            m_rep_reg    <= rep_reg;
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_frame        = m_frame_reg;
    assign m_ratio        = m_ratio_reg;
    assign m_paused       = m_paused_reg;
    assign m_repeats_done = m_rep_reg;

    // The divider only finishes while the control waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == S_WAIT))
        else $error("divider finished outside the wait state");

    // A paused tick never starts the divider and goes straight to the result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_EXEC) && (op_reg == OP_TICK) && paused_reg)
            |=> (state_reg == S_DONE))
        else $error("paused tick did not complete at once");

    // The repeat count changes only while an item is being executed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != S_WAIT) && (state_reg != S_EXEC)) |=> $stable(rep_reg))
        else $error("repeat count changed outside execution");

    // A new beat is only taken while no result is being prepared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted beat did not enter execution");

endmodule
